// ----- sv/lob_pkg.sv -----
package lob_pkg;

  localparam int COST_W      = 50;
  localparam int PRICE_OUT_W = 24;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_MUT,
    MODE_BEST,
    MODE_LVL
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUT,
    S_WRITE,
    S_BEST,
    S_LVL,
    S_MUL,
    S_ACC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic  in_ready;
    logic  load;
    logic  start;
    mode_e mode;
    logic  write_new;
    logic  mul;
    logic  acc;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic    busy;
    logic    done;
    logic    full;
    action_e act;
    logic    level_found;
    logic    want_zero;
    logic    want_last;
    logic    out_free;
  } sts_t;

endpackage

// ----- sv/lob_if.sv -----
interface lob_in_if #(
  parameter int ID_BITS     = 16,
  parameter int SYMBOL_BITS = 8,
  parameter int PRICE_BITS  = 24,
  parameter int QTY_BITS    = 20
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [ID_BITS-1:0]     ord_ref;
  logic [SYMBOL_BITS-1:0] symbol;
  logic                   side;
  logic [PRICE_BITS-1:0]  price;
  logic [QTY_BITS-1:0]    quantity;

  modport source (output valid, action, ord_ref, symbol, side, price, quantity, input ready);
  modport sink   (input valid, action, ord_ref, symbol, side, price, quantity, output ready);
endinterface

interface lob_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [lob_pkg::PRICE_OUT_W-1:0] best_sell;
  logic [lob_pkg::PRICE_OUT_W-1:0] best_buy;
  logic [lob_pkg::COST_W-1:0]      total_cost;

  modport source (output valid, status, best_sell, best_buy, total_cost, input ready);
  modport sink   (input valid, status, best_sell, best_buy, total_cost, output ready);
endinterface

// ----- sv/lob_ctrl.sv -----
module lob_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_action_i,
  input  lob_pkg::sts_t   sts_i,
  output lob_pkg::cmd_t   cmd_o
);

  lob_pkg::state_e state_q, state_d;
  logic            mut_go;

  assign mut_go = (in_action_i == lob_pkg::ACT_CANCEL) ||
                  ((in_action_i == lob_pkg::ACT_ADD) && !sts_i.full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lob_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lob_pkg::S_IDLE: begin
        if (in_valid_i) state_d = mut_go ? lob_pkg::S_MUT : lob_pkg::S_BEST;
      end
      lob_pkg::S_MUT: begin
        if (sts_i.done) begin
          state_d = (sts_i.act == lob_pkg::ACT_ADD) ? lob_pkg::S_WRITE : lob_pkg::S_BEST;
        end
      end
      lob_pkg::S_WRITE: state_d = lob_pkg::S_BEST;
      lob_pkg::S_BEST: begin
        if (sts_i.done) begin
          state_d = ((sts_i.act == lob_pkg::ACT_QUERY) && !sts_i.want_zero) ?
                    lob_pkg::S_LVL : lob_pkg::S_OUT;
        end
      end
      lob_pkg::S_LVL: begin
        if (sts_i.done) state_d = lob_pkg::S_MUL;
      end
      lob_pkg::S_MUL: state_d = sts_i.level_found ? lob_pkg::S_ACC : lob_pkg::S_OUT;
      lob_pkg::S_ACC: state_d = sts_i.want_last ? lob_pkg::S_OUT : lob_pkg::S_LVL;
      lob_pkg::S_OUT: begin
        if (sts_i.out_free) state_d = lob_pkg::S_IDLE;
      end
      default: state_d = lob_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mode = lob_pkg::MODE_BEST;
    case (state_q)
      lob_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i;
        cmd_o.start    = in_valid_i;
        cmd_o.mode     = mut_go ? lob_pkg::MODE_MUT : lob_pkg::MODE_BEST;
      end
      lob_pkg::S_MUT: begin
        cmd_o.start = sts_i.done && (sts_i.act != lob_pkg::ACT_ADD);
      end
      lob_pkg::S_WRITE: begin
        cmd_o.write_new = 1'b1;
        cmd_o.start     = 1'b1;
      end
      lob_pkg::S_BEST: begin
        cmd_o.start = sts_i.done && (sts_i.act == lob_pkg::ACT_QUERY) && !sts_i.want_zero;
        cmd_o.mode  = lob_pkg::MODE_LVL;
      end
      lob_pkg::S_LVL: cmd_o.mode = lob_pkg::MODE_LVL;
      lob_pkg::S_MUL: cmd_o.mul = sts_i.level_found;
      lob_pkg::S_ACC: begin
        cmd_o.acc   = 1'b1;
        cmd_o.start = !sts_i.want_last;
        cmd_o.mode  = lob_pkg::MODE_LVL;
      end
      lob_pkg::S_OUT: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- sv/lob_dp.sv -----
module lob_dp #(
  parameter int ENTRIES     = 64,
  parameter int SYMBOL_BITS = 8,
  parameter int ID_BITS     = 16,
  parameter int PRICE_BITS  = 24,
  parameter int QTY_BITS    = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lob_pkg::cmd_t                   cmd_i,
  input  logic [1:0]                      action_i,
  input  logic [ID_BITS-1:0]              ord_ref_i,
  input  logic [SYMBOL_BITS-1:0]          symbol_i,
  input  logic                            side_i,
  input  logic [PRICE_BITS-1:0]           price_i,
  input  logic [QTY_BITS-1:0]             quantity_i,
  input  logic                            out_ready_i,
  output lob_pkg::sts_t                   sts_o,
  output logic                            out_valid_o,
  output logic [1:0]                      status_o,
  output logic [lob_pkg::PRICE_OUT_W-1:0] best_sell_o,
  output logic [lob_pkg::PRICE_OUT_W-1:0] best_buy_o,
  output logic [lob_pkg::COST_W-1:0]      total_cost_o
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = ID_BITS + SYMBOL_BITS + 1;
  localparam int VW = PRICE_BITS + QTY_BITS;
  localparam int GW = QTY_BITS + AW;

  logic [KW-1:0] key_mem [ENTRIES];
  logic [VW-1:0] val_mem [ENTRIES];

  logic [ENTRIES-1:0]     valid_q, cancel_q;
  logic [CW-1:0]          count_q;
  logic                   busy_q, rd_v_q, found_q, out_valid_q;
  logic [AW-1:0]          idx_q, rd_i_q, slot_q;
  lob_pkg::mode_e         mode_q;
  logic [KW-1:0]          key_rd_q;
  logic [VW-1:0]          val_rd_q;
  lob_pkg::action_e       act_q;
  logic [ID_BITS-1:0]     id_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic                   side_q, full_q, slot_f_q;
  logic [PRICE_BITS-1:0]  price_q, bs_q, bb_q, lvl_q, floor_q;
  logic                   bs_f_q, bb_f_q, lvl_f_q, first_q;
  logic [QTY_BITS-1:0]    want_q, g_q, g_d;
  logic [GW-1:0]          grp_q;
  logic [VW-1:0]          prod_q;
  logic [lob_pkg::COST_W-1:0] total_q;
  logic [1:0]             status_q;
  logic [lob_pkg::PRICE_OUT_W-1:0] sell_out_q, buy_out_q;
  logic [lob_pkg::COST_W-1:0]      cost_out_q;

  logic [ID_BITS-1:0]     rd_id;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic                   rd_side, rd_valid, rd_cancel, rd_sell_hit;
  logic [PRICE_BITS-1:0]  rd_price;
  logic [QTY_BITS-1:0]    rd_qty;
  logic                   last_issue, done, cancel_hit;

  assign rd_id     = key_rd_q[KW-1 -: ID_BITS];
  assign rd_sym    = key_rd_q[SYMBOL_BITS:1];
  assign rd_side   = key_rd_q[0];
  assign rd_price  = val_rd_q[PRICE_BITS-1:0];
  assign rd_qty    = val_rd_q[PRICE_BITS +: QTY_BITS];
  assign rd_valid  = rd_v_q && valid_q[rd_i_q];
  assign rd_cancel = cancel_q[rd_i_q];
  assign rd_sell_hit = rd_valid && (rd_sym == sym_q) && rd_side &&
                       (first_q || (rd_price > floor_q));
  assign last_issue = (idx_q == AW'(ENTRIES - 1));
  assign done       = rd_v_q && (rd_i_q == AW'(ENTRIES - 1));
  assign cancel_hit = (mode_q == lob_pkg::MODE_MUT) && (act_q == lob_pkg::ACT_CANCEL) &&
                      rd_valid && rd_cancel && (rd_id == id_q) && !found_q;
  assign g_d = (grp_q > GW'(want_q)) ? want_q : grp_q[QTY_BITS-1:0];

  // sweep control and table flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      rd_v_q      <= 1'b0;
      mode_q      <= lob_pkg::MODE_BEST;
      valid_q     <= '0;
      cancel_q    <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q <= busy_q;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        mode_q <= cmd_i.mode;
      end else if (busy_q) begin
        idx_q <= idx_q + AW'(1);
        if (last_issue) busy_q <= 1'b0;
      end
      if (cmd_i.load) found_q <= 1'b0;
      if ((mode_q == lob_pkg::MODE_MUT) && (act_q == lob_pkg::ACT_ADD) && rd_valid &&
          (rd_id == id_q)) begin
        cancel_q[rd_i_q] <= 1'b0;
      end
      if (cancel_hit) begin
        valid_q[rd_i_q] <= 1'b0;
        found_q         <= 1'b1;
        count_q         <= count_q - CW'(1);
      end
      if (cmd_i.write_new) begin
        valid_q[slot_q]  <= 1'b1;
        cancel_q[slot_q] <= 1'b1;
        count_q          <= count_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // table memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_new) begin
      key_mem[slot_q] <= {id_q, sym_q, side_q};
      val_mem[slot_q] <= {want_q, price_q};
    end
    key_rd_q <= key_mem[idx_q];
    val_rd_q <= val_mem[idx_q];
    rd_i_q   <= idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= lob_pkg::action_e'(action_i);
      id_q    <= ord_ref_i;
      sym_q   <= symbol_i;
      side_q  <= side_i;
      price_q <= price_i;
      want_q  <= quantity_i;
      full_q  <= (count_q == CW'(ENTRIES));
      total_q <= '0;
      first_q <= 1'b1;
    end
    if (cmd_i.start) begin
      case (cmd_i.mode)
        lob_pkg::MODE_MUT: slot_f_q <= 1'b0;
        lob_pkg::MODE_BEST: begin
          bs_f_q <= 1'b0;
          bb_f_q <= 1'b0;
        end
        lob_pkg::MODE_LVL: lvl_f_q <= 1'b0;
        default: slot_f_q <= 1'b0;
      endcase
    end
    if (rd_v_q) begin
      case (mode_q)
        lob_pkg::MODE_MUT: begin
          if (!valid_q[rd_i_q] && !slot_f_q) begin
            slot_q   <= rd_i_q;
            slot_f_q <= 1'b1;
          end
        end
        lob_pkg::MODE_BEST: begin
          if (rd_valid && (rd_sym == sym_q)) begin
            if (rd_side) begin
              if (!bs_f_q || (rd_price < bs_q)) bs_q <= rd_price;
              bs_f_q <= 1'b1;
            end else begin
              if (!bb_f_q || (rd_price > bb_q)) bb_q <= rd_price;
              bb_f_q <= 1'b1;
            end
          end
        end
        lob_pkg::MODE_LVL: begin
          if (rd_sell_hit) begin
            if (!lvl_f_q || (rd_price < lvl_q)) begin
              lvl_q <= rd_price;
              grp_q <= GW'(rd_qty);
            end else if (rd_price == lvl_q) begin
              grp_q <= grp_q + GW'(rd_qty);
            end
            lvl_f_q <= 1'b1;
          end
        end
        default: slot_f_q <= slot_f_q;
      endcase
    end
    if (cmd_i.mul) begin
      g_q    <= g_d;
      prod_q <= VW'(lvl_q) * VW'(g_d);
    end
    if (cmd_i.acc) begin
      total_q <= total_q + lob_pkg::COST_W'(prod_q);
      want_q  <= want_q - g_q;
      floor_q <= lvl_q;
      first_q <= 1'b0;
    end
    if (cmd_i.out_load) begin
      if ((act_q == lob_pkg::ACT_ADD) && full_q) begin
        status_q <= lob_pkg::STATUS_FULL;
      end else if ((act_q == lob_pkg::ACT_CANCEL) && !found_q) begin
        status_q <= lob_pkg::STATUS_NOT_FOUND;
      end else begin
        status_q <= lob_pkg::STATUS_DONE;
      end
      sell_out_q <= bs_f_q ? lob_pkg::PRICE_OUT_W'(bs_q) : '0;
      buy_out_q  <= bb_f_q ? lob_pkg::PRICE_OUT_W'(bb_q) : '0;
      cost_out_q <= total_q;
    end
  end

  always_comb begin
    sts_o.busy        = busy_q || rd_v_q;
    sts_o.done        = done;
    sts_o.full        = (count_q == CW'(ENTRIES));
    sts_o.act         = act_q;
    sts_o.level_found = lvl_f_q;
    sts_o.want_zero   = (want_q == '0);
    sts_o.want_last   = (want_q == g_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign best_sell_o  = sell_out_q;
  assign best_buy_o   = buy_out_q;
  assign total_cost_o = cost_out_q;

endmodule

// ----- sv/limit_order_book_table_unit.sv -----
// one item at a time; a table sweep reads one entry per cycle
// zero-quantity queries, unused actions and full adds: one sweep
// cancel: two sweeps; accepted add: two sweeps with a slot write between them
// query filling L price levels: (L+1) sweeps; sells run out: (L+2) sweeps
// result turns valid as input ready returns; a stalled receiver delays the next transfer
// reset: asynchronous active low, clears the valid flags, order count and controller
module limit_order_book_table_unit #(
  parameter int ENTRIES     = 64,
  parameter int SYMBOL_BITS = 8,
  parameter int ID_BITS     = 16,
  parameter int PRICE_BITS  = 24,
  parameter int QTY_BITS    = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  lob_in_if.sink    in_i,
  lob_out_if.source out_o
);

  lob_pkg::cmd_t cmd;
  lob_pkg::sts_t sts;

  lob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lob_dp #(
    .ENTRIES     (ENTRIES),
    .SYMBOL_BITS (SYMBOL_BITS),
    .ID_BITS     (ID_BITS),
    .PRICE_BITS  (PRICE_BITS),
    .QTY_BITS    (QTY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (in_i.action),
    .ord_ref_i    (in_i.ord_ref),
    .symbol_i     (in_i.symbol),
    .side_i       (in_i.side),
    .price_i      (in_i.price),
    .quantity_i   (in_i.quantity),
    .out_ready_i  (out_o.ready),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .status_o     (out_o.status),
    .best_sell_o  (out_o.best_sell),
    .best_buy_o   (out_o.best_buy),
    .total_cost_o (out_o.total_cost)
  );

  assign in_i.ready = cmd.in_ready;

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_new |-> !sts.full)
    else $error("slot write into a full table");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after a transfer");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> (!sts.busy || sts.done))
    else $error("sweep started while one runs");

endmodule
